[rtl/pal_pkg.sv]
// Shared constants, codes and types for the positional array list.
`timescale 1ns / 1ps

package pal_pkg;

  // List size and field widths
  localparam int Capacity  = 128;
  localparam int WordW     = 32;
  localparam int PosW      = 8;
  localparam int StatusW   = 2;
  localparam int CountOutW = 8;
  localparam int CntW      = $clog2(Capacity + 1);
  localparam int IdxW      = $clog2(Capacity);
  localparam int CmpW      = (CntW > PosW) ? CntW : PosW;

  // Read-out tree: cells are OR-ed in groups, the group results registered
  localparam int GroupSize = 16;
  localparam int Groups    = (Capacity + GroupSize - 1) / GroupSize;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_APPEND    = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_AT    = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_LAST  = 3'd5,
    OP_READ      = 3'd6
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_NOPOS = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rd;
    logic [CntW-1:0]  at;
    logic [WordW-1:0] word;
  } cell_ctrl_t;

endpackage

[rtl/pal_cell.sv]
// One list cell: holds a single word and shifts with its neighbors.
`timescale 1ns / 1ps

module pal_cell (
  input  logic                     clk_i,
  input  pal_pkg::cell_ctrl_t      ctrl_i,
  input  logic [pal_pkg::IdxW-1:0] idx_i,
  input  logic [pal_pkg::WordW-1:0] lower_i,
  input  logic [pal_pkg::WordW-1:0] upper_i,
  output logic [pal_pkg::WordW-1:0] word_o,
  output logic [pal_pkg::WordW-1:0] hit_o
);
  import pal_pkg::*;

  logic [WordW-1:0] word_q, word_d;
  logic [CntW-1:0]  idx_ext;

  assign idx_ext = CntW'(idx_i);

  // Pick the next word: take the new word, shift up, shift down or hold
  always_comb begin
    word_d = word_q;
    if (ctrl_i.ins) begin
      if (idx_ext == ctrl_i.at) begin
        word_d = ctrl_i.word;
      end else if (idx_ext > ctrl_i.at) begin
        word_d = lower_i;
      end
    end else if (ctrl_i.del) begin
      if (idx_ext >= ctrl_i.at) begin
        word_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

  // Drive the read bus only when this cell is the addressed one
  assign hit_o = (idx_ext == ctrl_i.at) ? word_q : '0;

endmodule

[rtl/pal_chain.sv]
// Row of list cells plus the registered read-out tree.
`timescale 1ns / 1ps

module pal_chain (
  input  logic                      clk_i,
  input  pal_pkg::cell_ctrl_t       ctrl_i,
  output logic [pal_pkg::WordW-1:0] rd_word_o
);
  import pal_pkg::*;

  logic [WordW-1:0] word_w [Capacity];
  logic [WordW-1:0] hit_w  [Groups*GroupSize];
  logic [WordW-1:0] grp_q  [Groups];
  logic [WordW-1:0] grp_d  [Groups];

  // Build the row; the ends see zero from their missing neighbor
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [WordW-1:0] lower_w, upper_w;
    if (i == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_mid_lo
      assign lower_w = word_w[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_mid_hi
      assign upper_w = word_w[i+1];
    end
    pal_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .idx_i   (IdxW'(i)),
      .lower_i (lower_w),
      .upper_i (upper_w),
      .word_o  (word_w[i]),
      .hit_o   (hit_w[i])
    );
  end

  // Pad the last group with zeros
  for (genvar i = Capacity; i < Groups*GroupSize; i++) begin : g_pad
    assign hit_w[i] = '0;
  end

  // First tree level: OR each group of cell hits
  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GroupSize; k++) begin
        grp_d[g] = grp_d[g] | hit_w[g*GroupSize + k];
      end
    end
  end

  // Capture the group results on a read request
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      for (int g = 0; g < Groups; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  // Second tree level: OR the registered groups
  always_comb begin
    rd_word_o = '0;
    for (int g = 0; g < Groups; g++) begin
      rd_word_o = rd_word_o | grp_q[g];
    end
  end

endmodule

[rtl/positional_array_list.sv]
// Top level of the positional array list: request decode, count and result register.
//
// Usage: a request carries an opcode (insert front, append, insert at,
// delete at, delete front, delete last, read), a 32-bit word and a zero-based
// position. Every accepted request yields exactly one result on the output
// channel: a status, the word read (zero unless a read succeeds) and the
// entry count after the request. Both channels use valid/ready.
// Inserts and deletes other than delete last shift the cells from the
// position upward in parallel in the cycle the request is accepted; their
// result is registered at that edge. A successful read goes through a
// two-level OR tree over the cells: the group results are registered on
// acceptance and the result is loaded from them in the S_READ state.
// Throughput is one request per cycle for inserts, deletes and failing
// requests while the receiver takes results; a successful read blocks new requests until its result is loaded.
// A new request is taken while the result register is empty or being taken
// in the same cycle; a stalled receiver holds the result and blocks input.
// Reset empties the list (count zero) and clears the handshake state; the
// cell contents are left as they are and are never read before written.
`timescale 1ns / 1ps

module positional_array_list (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          opcode_i,
  input  logic signed [pal_pkg::WordW-1:0]    item_value_i,
  input  logic [pal_pkg::PosW-1:0]            slot_position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pal_pkg::StatusW-1:0]         status_o,
  output logic signed [pal_pkg::WordW-1:0]    read_word_o,
  output logic [pal_pkg::CountOutW-1:0]       count_after_o
);
  import pal_pkg::*;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q, out_valid_d;
  logic [StatusW-1:0]  status_q;
  logic [WordW-1:0]    word_q;
  logic [CountOutW-1:0] count_out_q;

  logic                accept;
  logic                ins, del, rd;
  logic [CntW-1:0]     at;
  status_e             sts;
  logic [CmpW-1:0]     pos_ext, cnt_ext;
  logic                full, empty;
  cell_ctrl_t          ctrl;
  logic [WordW-1:0]    rd_word;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign pos_ext = CmpW'(slot_position_i);
  assign cnt_ext = CmpW'(count_q);
  assign full    = (count_q == CntW'(Capacity));
  assign empty   = (count_q == '0);

  // Decode the request against the current count
  always_comb begin
    ins     = 1'b0;
    del     = 1'b0;
    rd      = 1'b0;
    at      = '0;
    sts     = STS_OK;
    count_d = count_q;
    unique case (opcode_i)
      OP_INS_FRONT, OP_APPEND, OP_INS_AT: begin
        if (full) begin
          sts = STS_FULL;
        end else begin
          ins     = 1'b1;
          count_d = CntW'(count_q + 1'b1);
          if (opcode_i == OP_INS_FRONT) begin
            at = '0;
          end else if (opcode_i == OP_APPEND || pos_ext > cnt_ext) begin
            at = count_q;
          end else begin
            at = CntW'(pos_ext);
          end
        end
      end
      OP_DEL_AT: begin
        if (empty) begin
          sts = STS_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          sts = STS_NOPOS;
        end else begin
          del     = 1'b1;
          at      = CntW'(pos_ext);
          count_d = CntW'(count_q - 1'b1);
        end
      end
      OP_DEL_FRONT: begin
        if (empty) begin
          sts = STS_EMPTY;
        end else begin
          del     = 1'b1;
          count_d = CntW'(count_q - 1'b1);
        end
      end
      OP_DEL_LAST: begin
        if (empty) begin
          sts = STS_EMPTY;
        end else begin
          count_d = CntW'(count_q - 1'b1);
        end
      end
      OP_READ: begin
        if (empty) begin
          sts = STS_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          sts = STS_NOPOS;
        end else begin
          rd = 1'b1;
          at = CntW'(pos_ext);
        end
      end
      default: begin
      end
    endcase
  end

  // Broadcast the shift or read command to the row
  always_comb begin
    ctrl.ins  = ins && accept;
    ctrl.del  = del && accept;
    ctrl.rd   = rd && accept;
    ctrl.at   = at;
    ctrl.word = item_value_i;
  end

  pal_chain u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .rd_word_o (rd_word)
  );

  // Next state: a successful read waits in S_READ for the registered tree
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && rd) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register valid: set on a finished request, drop when taken
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !rd) begin
          out_valid_d = 1'b1;
        end
      end
      S_READ: begin
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= sts;
      count_out_q <= CountOutW'(count_d);
      word_q      <= '0;
    end else if (state_q == S_READ) begin
      word_q <= rd_word;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_word_o   = word_q;
  assign count_after_o = count_out_q;

endmodule

[tb/sv/tb_positional_array_list.sv]
// Self-checking testbench for the positional array list: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_positional_array_list;
  import pal_pkg::*;

  // Opcode with no operation behind it; the block must leave the list alone
  localparam logic [2:0] OpUnused = 3'd7;

  localparam int ResetCycles   = 6;
  localparam int PhaseRequests = 480;
  localparam int QuietLimit    = 2000;
  localparam int TailCycles    = 8;
  localparam int FlipAfterHits = 6;

  typedef struct {
    status_e                 status;
    logic signed [WordW-1:0] word;
    logic [CountOutW-1:0]    count;
  } list_result_t;

  typedef struct {
    logic [2:0]              op;
    logic signed [WordW-1:0] value;
    logic [PosW-1:0]         pos;
    bit                      fixed;
    list_result_t            outcome;
  } table_row_t;

  typedef enum {FILL_UP, DRAIN} drift_e;

  localparam list_result_t NoFixed = '{STS_OK, 32'sd0, 8'd0};

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [2:0]              opcode_i = 3'd0;
  logic signed [WordW-1:0] item_value_i = '0;
  logic [PosW-1:0]         slot_position_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [StatusW-1:0]      status_o;
  logic signed [WordW-1:0] read_word_o;
  logic [CountOutW-1:0]    count_after_o;

  // Shadow copy of the list
  logic signed [WordW-1:0] shadow_words [Capacity];
  int                      shadow_len = 0;

  list_result_t            pending_results [$];
  list_result_t            front_result;
  table_row_t              directed_rows [24];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int status_tally [4] = '{0, 0, 0, 0};
  int peak_len = 0;

  positional_array_list dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .item_value_i    (item_value_i),
    .slot_position_i (slot_position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .read_word_o     (read_word_o),
    .count_after_o   (count_after_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Apply one request to the shadow list and return the result it must produce
  function automatic list_result_t list_apply(input logic [2:0] op,
                                              input logic signed [WordW-1:0] value,
                                              input logic [PosW-1:0] pos);
    list_result_t res;
    int           at;
    res = NoFixed;
    at  = 0;
    case (op)
      OP_INS_FRONT, OP_APPEND, OP_INS_AT: begin
        if (shadow_len >= Capacity) begin
          res.status = STS_FULL;
        end else begin
          if (op == OP_INS_FRONT) at = 0;
          else if (op == OP_APPEND || int'(pos) > shadow_len) at = shadow_len;
          else at = int'(pos);
          for (int i = shadow_len; i > at; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[at] = value;
          shadow_len++;
        end
      end
      OP_DEL_AT: begin
        if (shadow_len == 0) begin
          res.status = STS_EMPTY;
        end else if (int'(pos) >= shadow_len) begin
          res.status = STS_NOPOS;
        end else begin
          for (int i = int'(pos); i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      OP_DEL_FRONT: begin
        if (shadow_len == 0) begin
          res.status = STS_EMPTY;
        end else begin
          for (int i = 0; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      OP_DEL_LAST: begin
        if (shadow_len == 0) res.status = STS_EMPTY;
        else shadow_len--;
      end
      OP_READ: begin
        if (shadow_len == 0) res.status = STS_EMPTY;
        else if (int'(pos) >= shadow_len) res.status = STS_NOPOS;
        else res.word = shadow_words[pos];
      end
      default: ;
    endcase
    res.count = shadow_len[CountOutW-1:0];
    return res;
  endfunction

  // Present one request, hold it until taken, then queue its expected result
  task automatic send_request(input logic [2:0] op, input logic signed [WordW-1:0] value,
                              input logic [PosW-1:0] pos, input bit fixed,
                              input list_result_t outcome);
    list_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    item_value_i    <= value;
    slot_position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = list_apply(op, value, pos);
    pending_results.push_back(fixed ? outcome : predicted);
    requests_sent++;
    if (shadow_len > peak_len) peak_len = shadow_len;
  endtask

  // Draw a random request, biased toward growing or draining the list
  task automatic pick_request(input drift_e drift, output logic [2:0] op,
                              output logic signed [WordW-1:0] value,
                              output logic [PosW-1:0] pos);
    int roll;
    int kind;
    roll = $urandom_range(99);
    kind = $urandom_range(2);
    if (roll < 5) begin
      op = ($urandom_range(1) == 0) ? OpUnused : 3'($urandom_range(6));
    end else if ((drift == FILL_UP && roll < 70) || (drift == DRAIN && roll >= 85)) begin
      op = (kind == 0) ? OP_INS_FRONT : (kind == 1) ? OP_APPEND : OP_INS_AT;
    end else if (roll < 85 && roll >= 70) begin
      op = OP_READ;
    end else begin
      op = (kind == 0) ? OP_DEL_AT : (kind == 1) ? OP_DEL_FRONT : OP_DEL_LAST;
    end

    // Mostly legal positions, some past the end, a few beyond the list size
    case ($urandom_range(9))
      7, 8:    pos = PosW'($urandom_range(0, Capacity));
      9:       pos = PosW'($urandom_range(0, 255));
      default: begin
        if (op == OP_INS_AT || shadow_len == 0) pos = PosW'($urandom_range(0, shadow_len));
        else pos = PosW'($urandom_range(0, shadow_len - 1));
      end
    endcase

    case ($urandom_range(7))
      0:       value = 32'sh80000000;
      1:       value = 32'sh7FFFFFFF;
      2:       value = -32'sd1;
      3:       value = 32'sd0;
      default: value = $urandom;
    endcase
  endtask

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: status %0d word %0d count %0d",
                                  status_o, read_word_o, count_after_o));
      end else begin
        front_result = pending_results.pop_front();
        results_checked++;
        status_tally[front_result.status]++;
        if (status_o !== front_result.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, front_result.status));
        if (read_word_o !== front_result.word)
          report_mismatch($sformatf("read_word got %0d want %0d", read_word_o,
                                    front_result.word));
        if (count_after_o !== front_result.count)
          report_mismatch($sformatf("count_after got %0d want %0d", count_after_o,
                                    front_result.count));
      end
    end
  end

  // Count cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk_i); while (quiet_cycles < QuietLimit);
    $display("timeout after %0d quiet cycles, %0d results outstanding", quiet_cycles,
             pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [2:0]              op;
    logic signed [WordW-1:0] value;
    logic [PosW-1:0]         pos;
    drift_e                  drift;
    int                      edge_hits;
    int                      counted;
    int                      idle_pcts [4];
    int                      stall_pcts [4];

    idle_pcts  = '{0, 58, 0, 7};
    stall_pcts = '{0, 0, 58, 7};
    drift      = FILL_UP;
    edge_hits  = 0;

    // Empty-list errors, extremes, insert/delete past the end, unused opcode
    directed_rows = '{
      '{OP_READ,      32'sd0,          8'd0,   1'b1, '{STS_EMPTY, 32'sd0, 8'd0}},
      '{OP_DEL_AT,    32'sd0,          8'd0,   1'b1, '{STS_EMPTY, 32'sd0, 8'd0}},
      '{OP_DEL_FRONT, 32'sd0,          8'd0,   1'b1, '{STS_EMPTY, 32'sd0, 8'd0}},
      '{OP_DEL_LAST,  32'sd0,          8'd0,   1'b1, '{STS_EMPTY, 32'sd0, 8'd0}},
      '{OpUnused,     32'sd0,          8'd0,   1'b1, '{STS_OK,    32'sd0, 8'd0}},
      '{OP_INS_AT,    32'sh7FFFFFFF,   8'd128, 1'b1, '{STS_OK,    32'sd0, 8'd1}},
      '{OP_INS_FRONT, 32'sh80000000,   8'd0,   1'b1, '{STS_OK,    32'sd0, 8'd2}},
      '{OP_APPEND,    -32'sd1,         8'd255, 1'b1, '{STS_OK,    32'sd0, 8'd3}},
      '{OP_READ,      32'sd0,          8'd0,   1'b1, '{STS_OK, 32'sh80000000, 8'd3}},
      '{OP_READ,      32'sd0,          8'd2,   1'b0, NoFixed},
      '{OP_READ,      32'sd0,          8'd3,   1'b1, '{STS_NOPOS, 32'sd0, 8'd3}},
      '{OP_READ,      32'sd0,          8'd128, 1'b1, '{STS_NOPOS, 32'sd0, 8'd3}},
      '{OP_READ,      32'sd0,          8'd255, 1'b0, NoFixed},
      '{OP_INS_AT,    32'sh5A5A5A5A,   8'd1,   1'b0, NoFixed},
      '{OP_INS_AT,    32'sd0,          8'd4,   1'b0, NoFixed},
      '{OP_DEL_AT,    32'sd0,          8'd5,   1'b1, '{STS_NOPOS, 32'sd0, 8'd5}},
      '{OP_DEL_AT,    32'sd0,          8'd1,   1'b0, NoFixed},
      '{OP_READ,      32'sd0,          8'd1,   1'b0, NoFixed},
      '{OP_DEL_FRONT, 32'sd0,          8'd0,   1'b0, NoFixed},
      '{OP_DEL_LAST,  32'sd0,          8'd0,   1'b0, NoFixed},
      '{OpUnused,     32'shA5A5A5A5,   8'd170, 1'b0, NoFixed},
      '{OP_DEL_AT,    32'sd0,          8'd1,   1'b0, NoFixed},
      '{OP_DEL_LAST,  32'sd0,          8'd0,   1'b0, NoFixed},
      '{OP_READ,      32'sd0,          8'd0,   1'b1, '{STS_EMPTY, 32'sd0, 8'd0}}
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pos,
                   directed_rows[i].fixed, directed_rows[i].outcome);

    // Random traffic, one pacing phase after another
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_pcts[phase];
      recv_stall_pct = stall_pcts[phase];
      counted        = 0;
      while (counted < PhaseRequests) begin
        pick_request(drift, op, value, pos);
        send_request(op, value, pos, 1'b0, NoFixed);
        if (op != OpUnused) counted++;
        // Flip direction after lingering at full or at empty for a while
        if ((drift == FILL_UP && shadow_len == Capacity) ||
            (drift == DRAIN && shadow_len == 0)) begin
          edge_hits++;
          if (edge_hits >= FlipAfterHits) begin
            drift     = (drift == FILL_UP) ? DRAIN : FILL_UP;
            edge_hits = 0;
          end
        end
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then give the read pipeline time to misbehave
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Sent %0d requests over four pacing phases; checked %0d results, peak length %0d.",
             requests_sent, results_checked, peak_len);
    $display("Status mix: ok %0d, full %0d, empty %0d, no position %0d; mismatches %0d.",
             status_tally[STS_OK], status_tally[STS_FULL], status_tally[STS_EMPTY],
             status_tally[STS_NOPOS], mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
